>>> hdl/scrolling_seven_segment_scanner_unit_macros.svh
// assertion macros shared by the scanner rtl
`ifndef SCROLLING_SEVEN_SEGMENT_SCANNER_UNIT_MACROS_SVH
`define SCROLLING_SEVEN_SEGMENT_SCANNER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sss_pkg.sv
// shared types, constants and glyph lookup for the scrolling segment scanner
package sss_pkg;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W       = ADDR_W + 1;
  localparam int unsigned DIGITS      = 8;
  localparam int unsigned SLOT_W      = $clog2(DIGITS);
  localparam int unsigned BYTE_BITS   = 8;
  localparam int unsigned SCAN_BITS   = 2 * BYTE_BITS;
  localparam int unsigned SCAN_CNT_W  = $clog2(SCAN_BITS);
  localparam int unsigned IDX_OUT_W   = 3;

  localparam logic [BYTE_BITS-1:0] SEL_TOP   = 8'h80;
  localparam logic [BYTE_BITS-1:0] WIN_RESET = 8'd11;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SCROLL = 2'd2,
    CMD_SCAN   = 2'd3
  } cmd_e;

  // operands of the shared increment-and-wrap unit
  typedef struct packed {
    logic [CNT_W-1:0] a;
    logic [CNT_W-1:0] lim;
  } unit_op_t;

  typedef struct packed {
    logic [CNT_W-1:0] nxt;
    logic             hit;
  } unit_res_t;

  // segment on-masks, bit 0 = a .. bit 6 = g
  typedef struct packed {
    logic                 two;
    logic [BYTE_BITS-1:0] b0;
    logic [BYTE_BITS-1:0] b1;
  } glyph_t;

  localparam logic [BYTE_BITS-1:0] LETTER_ON [26] = '{
    8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h6F, 8'h76, 8'h30, 8'h1E, 8'h76, 8'h38, 8'h33,
    8'h54, 8'h3F, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h3E, 8'h1C, 8'h3C, 8'h76, 8'h6E, 8'h5B
  };

  localparam logic [BYTE_BITS-1:0] DIGIT_ON [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  function automatic glyph_t glyph(input logic [7:0] ch);
    logic [7:0] up;
    glyph_t     g;
    up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
    g  = '0;
    if (up == "M") begin
      g.two = 1'b1;
      g.b0  = 8'h33;
      g.b1  = 8'h27;
    end else if (up == "W") begin
      g.two = 1'b1;
      g.b0  = 8'h3C;
      g.b1  = 8'h1E;
    end else if (ch == "h") begin
      // lowercase h keeps its own glyph
      g.b0 = 8'h74;
    end else if (up >= "A" && up <= "Z") begin
      g.b0 = LETTER_ON[5'(up - "A")];
    end else if (ch >= "0" && ch <= "9") begin
      g.b0 = DIGIT_ON[4'(ch - "0")];
    end else if (ch == ".") begin
      g.b0 = 8'h80;
    end else if (ch == "-") begin
      g.b0 = 8'h40;
    end else begin
      g.b0 = 8'h00;
    end
    return g;
  endfunction

endpackage

>>> hdl/sss_ram.sv
// generic single-write, single-read ram with registered read data
module sss_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hdl/sss_inc_wrap.sv
// shared increment unit: a + 1, wrapping to zero when it reaches the limit
module sss_inc_wrap (
  input  sss_pkg::unit_op_t  op_i,
  output sss_pkg::unit_res_t res_o
);

  logic [sss_pkg::CNT_W-1:0] sum;

  always_comb begin
    sum       = op_i.a + sss_pkg::CNT_W'(1);
    res_o.hit = (sum == op_i.lim);
    res_o.nxt = res_o.hit ? '0 : sum;
  end

endmodule

>>> hdl/sss_scan.sv
// serializer that shifts one select byte and one segment byte out msb first
module sss_scan (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             load_i,
  input  logic [sss_pkg::SCAN_BITS-1:0]    word_i,
  input  logic [sss_pkg::IDX_OUT_W-1:0]    slot_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             serial_data_o,
  output logic [sss_pkg::IDX_OUT_W-1:0]    digit_index_o,
  output logic                             last_bit_o
);

  logic [sss_pkg::SCAN_BITS-1:0]  sh_q, sh_d;
  logic [sss_pkg::SCAN_CNT_W-1:0] cnt_q, cnt_d;
  logic [sss_pkg::IDX_OUT_W-1:0]  slot_q, slot_d;
  logic                           valid_q, valid_d;
  logic                           last;

  assign last = (cnt_q == sss_pkg::SCAN_CNT_W'(sss_pkg::SCAN_BITS - 1));

  always_comb begin
    sh_d    = sh_q;
    cnt_d   = cnt_q;
    slot_d  = slot_q;
    valid_d = valid_q;
    if (load_i) begin
      sh_d    = word_i;
      cnt_d   = '0;
      slot_d  = slot_i;
      valid_d = 1'b1;
    end else if (valid_q && out_ready_i) begin
      sh_d  = {sh_q[sss_pkg::SCAN_BITS-2:0], 1'b0};
      cnt_d = cnt_q + sss_pkg::SCAN_CNT_W'(1);
      if (last) begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    slot_q <= slot_d;
  end

  assign out_valid_o   = valid_q;
  assign serial_data_o = sh_q[sss_pkg::SCAN_BITS-1];
  assign digit_index_o = slot_q;
  assign last_bit_o    = last;

endmodule

>>> hdl/scrolling_seven_segment_scanner_unit.sv
// scrolling seven-segment scanner: command sequencer, pattern store and window
// clear acts at once; append stores one byte, or two for two-byte glyphs (M, W)
// scroll runs ST_RD, ST_WR per slot: each slot needs a store read and a write-back
// scan loads, then gives 16 result items, one per cycle while out_ready_i is high
// ready drops until append or scroll ends and, for scan, until the last bit is taken
// reset clears count, position, digit and window (to 11); store contents stay undefined
module scrolling_seven_segment_scanner_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] char_code_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       serial_data_o,
  output logic [2:0] digit_index_o,
  output logic       last_bit_o
);

  `include "scrolling_seven_segment_scanner_unit_macros.svh"

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_APP  = 5'b00010,
    ST_APP2 = 5'b00100,
    ST_RD   = 5'b01000,
    ST_WR   = 5'b10000
  } state_e;

  localparam logic [sss_pkg::CNT_W-1:0] FULL_LIM = sss_pkg::CNT_W'(sss_pkg::STORE_DEPTH + 1);

  state_e                             state_q, state_d;
  logic [sss_pkg::CNT_W-1:0]          count_q, count_d;
  logic [sss_pkg::ADDR_W-1:0]         pos_q, pos_d;
  logic [sss_pkg::ADDR_W-1:0]         idx_q, idx_d;
  logic [sss_pkg::SLOT_W-1:0]         slot_q, slot_d;
  logic [sss_pkg::SLOT_W-1:0]         digit_q, digit_d;
  logic [sss_pkg::BYTE_BITS-1:0]      win_q [sss_pkg::DIGITS];
  sss_pkg::glyph_t                    glyph_q, glyph_d;

  sss_pkg::unit_op_t                  unit_op;
  sss_pkg::unit_res_t                 unit_res;

  logic                               accept;
  sss_pkg::cmd_e                      cmd;
  logic                               scan_busy;
  logic                               scan_load;
  logic [sss_pkg::SCAN_BITS-1:0]      scan_word;
  logic [sss_pkg::SLOT_W-1:0]         phys_pos;
  logic [sss_pkg::BYTE_BITS-1:0]      sel_byte;

  logic                               ram_we;
  logic [sss_pkg::BYTE_BITS-1:0]      ram_wdata;
  logic [sss_pkg::BYTE_BITS-1:0]      ram_rdata;
  logic                               win_we;

  assign cmd        = sss_pkg::cmd_e'(cmd_i);
  assign in_ready_o = (state_q == ST_IDLE) && !scan_busy;
  assign accept     = in_valid_i && in_ready_o;

  // shared unit operand select
  always_comb begin
    unit_op.a   = count_q;
    unit_op.lim = FULL_LIM;
    case (state_q)
      ST_RD: begin
        unit_op.a   = {1'b0, idx_q};
        unit_op.lim = count_q;
      end
      ST_WR: begin
        unit_op.a   = {1'b0, pos_q};
        unit_op.lim = count_q;
      end
      default: begin
        unit_op.a   = count_q;
        unit_op.lim = FULL_LIM;
      end
    endcase
  end

  sss_inc_wrap u_inc (
    .op_i  (unit_op),
    .res_o (unit_res)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pos_d     = pos_q;
    idx_d     = idx_q;
    slot_d    = slot_q;
    digit_d   = digit_q;
    glyph_d   = glyph_q;
    ram_we    = 1'b0;
    ram_wdata = ~glyph_q.b0;
    win_we    = 1'b0;
    scan_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            sss_pkg::CMD_CLEAR: begin
              count_d = '0;
              pos_d   = '0;
            end
            sss_pkg::CMD_APPEND: begin
              glyph_d = sss_pkg::glyph(char_code_i);
              state_d = ST_APP;
            end
            sss_pkg::CMD_SCROLL: begin
              // empty store: nothing to show
              if (count_q != '0) begin
                idx_d   = pos_q;
                slot_d  = '0;
                state_d = ST_RD;
              end
            end
            sss_pkg::CMD_SCAN: begin
              scan_load = 1'b1;
              if (digit_q == sss_pkg::SLOT_W'(sss_pkg::DIGITS - 1)) begin
                digit_d = '0;
              end else begin
                digit_d = digit_q + sss_pkg::SLOT_W'(1);
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_APP: begin
        ram_wdata = ~glyph_q.b0;
        // hit means the store is full and the byte is dropped
        if (!unit_res.hit) begin
          ram_we  = 1'b1;
          count_d = unit_res.nxt;
        end
        state_d = glyph_q.two ? ST_APP2 : ST_IDLE;
      end
      ST_APP2: begin
        ram_wdata = ~glyph_q.b1;
        if (!unit_res.hit) begin
          ram_we  = 1'b1;
          count_d = unit_res.nxt;
        end
        state_d = ST_IDLE;
      end
      ST_RD: begin
        idx_d   = unit_res.nxt[sss_pkg::ADDR_W-1:0];
        state_d = ST_WR;
      end
      ST_WR: begin
        win_we = 1'b1;
        if (slot_q == sss_pkg::SLOT_W'(sss_pkg::DIGITS - 1)) begin
          pos_d   = unit_res.nxt[sss_pkg::ADDR_W-1:0];
          state_d = ST_IDLE;
        end else begin
          slot_d  = slot_q + sss_pkg::SLOT_W'(1);
          state_d = ST_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      pos_q   <= '0;
      digit_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      digit_q <= digit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    slot_q  <= slot_d;
    glyph_q <= glyph_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(sss_pkg::DIGITS); i++) begin
        win_q[i] <= sss_pkg::WIN_RESET;
      end
    end else if (win_we) begin
      win_q[slot_q] <= ram_rdata;
    end
  end

  sss_ram #(
    .Width (sss_pkg::BYTE_BITS),
    .Depth (sss_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[sss_pkg::ADDR_W-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // slot s drives physical digit DIGITS-1-s
  always_comb begin
    phys_pos = sss_pkg::SLOT_W'(sss_pkg::DIGITS - 1) - digit_q;
    if (int'(phys_pos) < int'(sss_pkg::BYTE_BITS)) begin
      sel_byte = sss_pkg::SEL_TOP >> phys_pos;
    end else begin
      sel_byte = '0;
    end
    scan_word = {sel_byte, win_q[digit_q]};
  end

  sss_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (scan_load),
    .word_i        (scan_word),
    .slot_i        (sss_pkg::IDX_OUT_W'(digit_q)),
    .out_valid_o   (scan_busy),
    .out_ready_i   (out_ready_i),
    .serial_data_o (serial_data_o),
    .digit_index_o (digit_index_o),
    .last_bit_o    (last_bit_o)
  );

  assign out_valid_o = scan_busy;

  `SSS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= sss_pkg::CNT_W'(sss_pkg::STORE_DEPTH), "pattern count past store depth")
  `SSS_ASSERT_NOW(a_pos_in_range, count_q != '0, {1'b0, pos_q} < count_q, "scroll position outside stored text")
  `SSS_ASSERT_NEXT(a_scan_starts, accept && cmd == sss_pkg::CMD_SCAN, out_valid_o && !in_ready_o, "scan did not start shifting")

endmodule
